FILE: rtl/core/ffpr_pkg.sv
// Shared types, constants and the control program for the filtered force regulator.
// Used by every module under rtl/core; depends on nothing else.
package ffpr_pkg;

	// Configuration port geometry.
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;
	localparam int REG_IW = 3;

	// Register indexes.
	localparam logic [REG_IW-1:0] REG_ALPHA    = 3'd0;
	localparam logic [REG_IW-1:0] REG_SETPOINT = 3'd1;
	localparam logic [REG_IW-1:0] REG_PGAIN    = 3'd2;
	localparam logic [REG_IW-1:0] REG_IGAIN    = 3'd3;
	localparam logic [REG_IW-1:0] REG_MAXCORR  = 3'd4;
	localparam logic [REG_IW-1:0] REG_TRIGGER  = 3'd5;
	localparam logic [REG_IW-1:0] REG_PERIOD   = 3'd6;
	localparam logic [REG_IW-1:0] REG_DIR      = 3'd7;

	// Reset values of the registers.
	localparam logic [15:0] RST_ALPHA    = 16'd58982;
	localparam logic [14:0] RST_SETPOINT = 15'd512;
	localparam logic [23:0] RST_PGAIN    = 24'd400000;
	localparam logic [23:0] RST_IGAIN    = 24'd80000;
	localparam logic [22:0] RST_MAXCORR  = 23'd2500000;
	localparam logic [15:0] RST_TRIGGER  = 16'd128;
	localparam logic [23:0] RST_PERIOD   = 24'd16777;
	localparam logic        RST_DIR      = 1'b1;

	// Integral limit (10 N*s in 2^-17 N*s) and the 1 us floor on the period.
	localparam logic signed [31:0] INTEG_LIMIT = 32'sd1310720;
	localparam logic [23:0]        DT_FLOOR    = 24'd17;

	// Phase codes.
	localparam logic [1:0] PH_CONTACT = 2'd0;
	localparam logic [1:0] PH_SCAN    = 2'd1;

	typedef struct packed {
		logic [15:0]        alpha;
		logic [14:0]        setpoint;
		logic [23:0]        pgain;
		logic [23:0]        igain;
		logic [22:0]        maxcorr;
		logic signed [15:0] trigger;
		logic [23:0]        period;
		logic               dir_neg;
	} cfg_t;

	// Sequencer program counter.
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] PC_FIRST = 4'd1;
	localparam logic [PC_W-1:0] PC_EMIT  = 4'd12;

	// Multiplier operand selects.
	localparam logic [1:0] MA_ACC   = 2'd0;
	localparam logic [1:0] MA_X     = 2'd1;
	localparam logic [1:0] MA_ERR   = 2'd2;
	localparam logic [1:0] MA_INTEG = 2'd3;

	localparam logic [2:0] MB_ALPHA  = 3'd0;
	localparam logic [2:0] MB_ALPHAC = 3'd1;
	localparam logic [2:0] MB_DT     = 3'd2;
	localparam logic [2:0] MB_PGAIN  = 3'd3;
	localparam logic [2:0] MB_IGAIN  = 3'd4;

	// Accumulator operations, rounding constants and product alignments.
	localparam logic [1:0] SUM_HOLD = 2'd0;
	localparam logic [1:0] SUM_LOAD = 2'd1;
	localparam logic [1:0] SUM_ADD  = 2'd2;

	localparam logic [1:0] RND_15 = 2'd0;
	localparam logic [1:0] RND_23 = 2'd1;
	localparam logic [1:0] RND_30 = 2'd2;

	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_7  = 2'd1;
	localparam logic [1:0] SH_16 = 2'd2;

	// Sequencing conditions.
	localparam logic [1:0] C_NEXT     = 2'd0;
	localparam logic [1:0] C_WAIT_IN  = 2'd1;
	localparam logic [1:0] C_BR_IDLE  = 2'd2;
	localparam logic [1:0] C_WAIT_OUT = 2'd3;

	typedef struct packed {
		logic [1:0]      ma_sel;
		logic [2:0]      mb_sel;
		logic [1:0]      sum_op;
		logic [1:0]      rnd_sel;
		logic [1:0]      sh_sel;
		logic            wr_acc;
		logic            wr_err;
		logic            wr_integ;
		logic [1:0]      cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic active_now;
	} stat_t;

	// One control word per step.
	function automatic ctl_t ucode_word(input logic [PC_W-1:0] pc);
		ctl_t w;
		w.ma_sel   = MA_ACC;
		w.mb_sel   = MB_ALPHA;
		w.sum_op   = SUM_HOLD;
		w.rnd_sel  = RND_15;
		w.sh_sel   = SH_0;
		w.wr_acc   = 1'b0;
		w.wr_err   = 1'b0;
		w.wr_integ = 1'b0;
		w.cond     = C_NEXT;
		w.target   = PC_IDLE;
		unique case (pc)
			4'd0: begin
				w.cond = C_WAIT_IN;
			end
			4'd1: begin
				w.ma_sel  = MA_ACC;
				w.mb_sel  = MB_ALPHA;
				w.sum_op  = SUM_LOAD;
				w.rnd_sel = RND_15;
			end
			4'd2: begin
				w.ma_sel = MA_X;
				w.mb_sel = MB_ALPHAC;
				w.sum_op = SUM_ADD;
				w.sh_sel = SH_0;
			end
			4'd3: begin
				w.sum_op = SUM_ADD;
				w.sh_sel = SH_16;
			end
			4'd4: begin
				w.wr_acc = 1'b1;
			end
			4'd5: begin
				w.wr_err = 1'b1;
				w.cond   = C_BR_IDLE;
				w.target = PC_EMIT;
			end
			4'd6: begin
				w.ma_sel  = MA_ERR;
				w.mb_sel  = MB_DT;
				w.sum_op  = SUM_LOAD;
				w.rnd_sel = RND_30;
			end
			4'd7: begin
				w.sum_op = SUM_ADD;
				w.sh_sel = SH_0;
			end
			4'd8: begin
				w.wr_integ = 1'b1;
			end
			4'd9: begin
				w.ma_sel  = MA_ERR;
				w.mb_sel  = MB_PGAIN;
				w.sum_op  = SUM_LOAD;
				w.rnd_sel = RND_23;
			end
			4'd10: begin
				w.ma_sel = MA_INTEG;
				w.mb_sel = MB_IGAIN;
				w.sum_op = SUM_ADD;
				w.sh_sel = SH_0;
			end
			4'd11: begin
				w.sum_op = SUM_ADD;
				w.sh_sel = SH_7;
			end
			4'd12: begin
				w.cond   = C_WAIT_OUT;
				w.target = PC_IDLE;
			end
			default: begin
				w.cond   = C_WAIT_OUT;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/ffpr_cfg.sv
// Configuration register bank behind the APB-style port.
// Depends on ffpr_pkg for register indexes, reset values and cfg_t.
module ffpr_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ffpr_pkg::CFG_AW-1:0]  paddr,
	input  logic [ffpr_pkg::CFG_DW-1:0]  pwdata,
	output logic [ffpr_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready,
	output ffpr_pkg::cfg_t               cfg
);
	import ffpr_pkg::*;

	cfg_t              cfg_q;
	logic              wr_en;
	logic [REG_IW-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[CFG_AW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha    <= RST_ALPHA;
			cfg_q.setpoint <= RST_SETPOINT;
			cfg_q.pgain    <= RST_PGAIN;
			cfg_q.igain    <= RST_IGAIN;
			cfg_q.maxcorr  <= RST_MAXCORR;
			cfg_q.trigger  <= signed'(RST_TRIGGER);
			cfg_q.period   <= RST_PERIOD;
			cfg_q.dir_neg  <= RST_DIR;
		end else if (wr_en) begin
			unique case (idx)
				REG_ALPHA:    cfg_q.alpha    <= pwdata[15:0];
				REG_SETPOINT: cfg_q.setpoint <= pwdata[14:0];
				REG_PGAIN:    cfg_q.pgain    <= pwdata[23:0];
				REG_IGAIN:    cfg_q.igain    <= pwdata[23:0];
				REG_MAXCORR:  cfg_q.maxcorr  <= pwdata[22:0];
				REG_TRIGGER:  cfg_q.trigger  <= signed'(pwdata[15:0]);
				REG_PERIOD:   cfg_q.period   <= pwdata[23:0];
				REG_DIR:      cfg_q.dir_neg  <= pwdata[0];
				default:      cfg_q.dir_neg  <= cfg_q.dir_neg;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ALPHA:    prdata = {16'd0, cfg_q.alpha};
			REG_SETPOINT: prdata = {17'd0, cfg_q.setpoint};
			REG_PGAIN:    prdata = {8'd0, cfg_q.pgain};
			REG_IGAIN:    prdata = {8'd0, cfg_q.igain};
			REG_MAXCORR:  prdata = {9'd0, cfg_q.maxcorr};
			REG_TRIGGER:  prdata = {16'd0, cfg_q.trigger};
			REG_PERIOD:   prdata = {8'd0, cfg_q.period};
			REG_DIR:      prdata = {31'd0, cfg_q.dir_neg};
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/ffpr_seq.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on ffpr_pkg for ctl_t, stat_t and the program table.
module ffpr_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  ffpr_pkg::stat_t stat,
	output ffpr_pkg::ctl_t  ctl
);
	import ffpr_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic [PC_W-1:0] pc_inc;

	assign ctl    = ucode_word(pc_q);
	assign pc_inc = pc_q + PC_W'(1);

	always_comb begin
		unique case (ctl.cond)
			C_NEXT:     pc_d = pc_inc;
			C_WAIT_IN:  pc_d = stat.in_valid ? pc_inc : pc_q;
			C_BR_IDLE:  pc_d = stat.active_now ? pc_inc : ctl.target;
			C_WAIT_OUT: pc_d = stat.out_free ? ctl.target : pc_q;
			default:    pc_d = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_EMIT)
		else $error("step counter left the program");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cond == C_WAIT_IN && stat.in_valid) |=> (pc_q == PC_FIRST))
		else $error("accepted word did not start the program");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cond == C_WAIT_OUT && !stat.out_free) |=> $stable(pc_q))
		else $error("sequencer moved while the result register was blocked");

endmodule

FILE: rtl/core/ffpr_dp.sv
// Datapath: shared multiplier, rounding accumulator, filter and integral state,
// input latch and result register. Depends on ffpr_pkg for cfg_t, ctl_t and codes.
module ffpr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ffpr_pkg::cfg_t      cfg,
	input  ffpr_pkg::ctl_t      ctl,
	output ffpr_pkg::stat_t     stat,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic signed [15:0]  raw_force,
	input  logic [1:0]          phase,
	input  logic                ramp_past_enable,
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [23:0]  correction,
	output logic signed [15:0]  filtered_force,
	output logic                control_active
);
	import ffpr_pkg::*;

	localparam logic signed [61:0] RND15 = 62'sd1 <<< 15;
	localparam logic signed [61:0] RND23 = 62'sd1 <<< 23;
	localparam logic signed [61:0] RND30 = 62'sd1 <<< 30;

	// Latched input word.
	logic signed [15:0] x_q;
	logic [1:0]         phase_q;
	logic               ramp_q;

	// Regulator state and working registers.
	logic signed [31:0] acc_q;
	logic signed [21:0] integ_q;
	logic signed [34:0] err_q;
	logic               act_q;
	logic signed [59:0] prod_q;
	logic signed [61:0] sum_q;

	// Result register.
	logic               out_valid_q;
	logic signed [23:0] corr_q;
	logic signed [15:0] filt_q;
	logic               oact_q;

	logic               accept;
	logic               emit;
	logic               out_free;
	logic signed [15:0] x_in;
	logic signed [34:0] mul_a;
	logic signed [24:0] mul_b;
	logic [16:0]        alpha_c;
	logic [23:0]        dt;
	logic signed [61:0] prod_ext;
	logic signed [61:0] addend;
	logic signed [61:0] rnd;
	logic signed [15:0] filt;
	logic               enabled;
	logic               active_now;
	logic signed [34:0] err_new;
	logic signed [31:0] integ_sum;
	logic signed [21:0] integ_new;
	logic signed [37:0] u_full;
	logic signed [37:0] u_lim;
	logic signed [23:0] u_clamped;
	logic signed [23:0] corr_new;

	assign sample_stall = (ctl.cond != C_WAIT_IN);
	assign accept       = sample_valid && (ctl.cond == C_WAIT_IN);
	assign out_free     = !out_valid_q || !result_stall;
	assign emit         = (ctl.cond == C_WAIT_OUT) && out_free;

	// Contact-axis force; the one positive overflow saturates.
	always_comb begin
		if (cfg.dir_neg) begin
			x_in = raw_force;
		end else if (raw_force == -16'sd32768) begin
			x_in = 16'sd32767;
		end else begin
			x_in = -raw_force;
		end
	end

	assign alpha_c = 17'd65536 - {1'b0, cfg.alpha};
	assign dt      = (cfg.period < DT_FLOOR) ? DT_FLOOR : cfg.period;

	always_comb begin
		unique case (ctl.ma_sel)
			MA_ACC:   mul_a = 35'(acc_q);
			MA_X:     mul_a = 35'(x_q);
			MA_ERR:   mul_a = err_q;
			MA_INTEG: mul_a = 35'(integ_q);
			default:  mul_a = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.mb_sel)
			MB_ALPHA:  mul_b = signed'({9'd0, cfg.alpha});
			MB_ALPHAC: mul_b = signed'({8'd0, alpha_c});
			MB_DT:     mul_b = signed'({1'b0, dt});
			MB_PGAIN:  mul_b = signed'({1'b0, cfg.pgain});
			MB_IGAIN:  mul_b = signed'({1'b0, cfg.igain});
			default:   mul_b = '0;
		endcase
	end

	assign prod_ext = 62'(prod_q);

	always_comb begin
		unique case (ctl.sh_sel)
			SH_0:    addend = prod_ext;
			SH_7:    addend = prod_ext <<< 7;
			SH_16:   addend = prod_ext <<< 16;
			default: addend = prod_ext;
		endcase
	end

	always_comb begin
		unique case (ctl.rnd_sel)
			RND_15:  rnd = RND15;
			RND_23:  rnd = RND23;
			RND_30:  rnd = RND30;
			default: rnd = RND15;
		endcase
	end

	// Control enable decision on the freshly updated filter.
	assign filt    = acc_q[31:16];
	assign enabled = (cfg.setpoint != '0) && (cfg.maxcorr != '0);

	always_comb begin
		if (phase_q == PH_CONTACT) begin
			active_now = enabled && (ramp_q || (filt >= cfg.trigger));
		end else if (phase_q == PH_SCAN) begin
			active_now = enabled;
		end else begin
			active_now = 1'b0;
		end
	end

	assign err_new = signed'({4'd0, cfg.setpoint, 16'd0}) - 35'(acc_q);

	// Integral update with anti-windup clamp.
	assign integ_sum = 32'(integ_q) + 32'(signed'(sum_q[61:31]));

	always_comb begin
		if (integ_sum > INTEG_LIMIT) begin
			integ_new = INTEG_LIMIT[21:0];
		end else if (integ_sum < -INTEG_LIMIT) begin
			integ_new = 22'(-INTEG_LIMIT);
		end else begin
			integ_new = integ_sum[21:0];
		end
	end

	// PI output clamp and direction sign.
	assign u_full = sum_q[61:24];
	assign u_lim  = signed'({15'd0, cfg.maxcorr});

	always_comb begin
		if (u_full > u_lim) begin
			u_clamped = u_lim[23:0];
		end else if (u_full < -u_lim) begin
			u_clamped = 24'(-u_lim);
		end else begin
			u_clamped = u_full[23:0];
		end
		if (!act_q) begin
			corr_new = '0;
		end else if (cfg.dir_neg) begin
			corr_new = -u_clamped;
		end else begin
			corr_new = u_clamped;
		end
	end

	assign stat.in_valid   = sample_valid;
	assign stat.out_free   = out_free;
	assign stat.active_now = active_now;

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= x_in;
			phase_q <= phase;
			ramp_q  <= ramp_past_enable;
		end
		prod_q <= mul_a * mul_b;
		unique case (ctl.sum_op)
			SUM_LOAD: sum_q <= rnd;
			SUM_ADD:  sum_q <= sum_q + addend;
			default:  sum_q <= sum_q;
		endcase
		if (ctl.wr_err) begin
			err_q <= err_new;
			act_q <= active_now;
		end
		if (emit) begin
			corr_q <= corr_new;
			filt_q <= filt;
			oact_q <= act_q;
		end
	end

	// Regulator state and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_acc) begin
				acc_q <= sum_q[47:16];
			end
			if (ctl.wr_err && !active_now) begin
				integ_q <= '0;
			end else if (ctl.wr_integ) begin
				integ_q <= integ_new;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid   = out_valid_q;
	assign correction     = corr_q;
	assign filtered_force = filt_q;
	assign control_active = oact_q;

	a_integ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(integ_q) <= INTEG_LIMIT) && (32'(integ_q) >= -INTEG_LIMIT))
		else $error("integral escaped its clamp");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !control_active) |-> (correction == '0))
		else $error("inactive word carries a nonzero correction");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(ctl.cond == C_WAIT_OUT))
		else $error("result appeared outside the emit step");

endmodule

FILE: rtl/core/filtered_force_pi_regulator.sv
// Filtered force PI regulator; depends on ffpr_pkg, ffpr_cfg, ffpr_seq and ffpr_dp.
// An active tick runs the filter steps, the activity decision and the PI steps before its
// result is registered in the emit step, and the next sample is taken only after that step;
// an inactive tick skips the PI steps. All multiplies share one 35x25 multiplier, and a result
// held by result_stall delays the emit step and with it the next sample.
// Reset restores register defaults, clears the filter and integral, drops any pending result.
module filtered_force_pi_regulator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ffpr_pkg::CFG_AW-1:0]  paddr,
	input  logic [ffpr_pkg::CFG_DW-1:0]  pwdata,
	output logic [ffpr_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  logic signed [15:0]           raw_force,
	input  logic [1:0]                   phase,
	input  logic                         ramp_past_enable,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [23:0]           correction,
	output logic signed [15:0]           filtered_force,
	output logic                         control_active
);
	import ffpr_pkg::*;

	cfg_t  cfg;
	ctl_t  ctl;
	stat_t stat;

	ffpr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ffpr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	ffpr_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.ctl              (ctl),
		.stat             (stat),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.raw_force        (raw_force),
		.phase            (phase),
		.ramp_past_enable (ramp_past_enable),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.correction       (correction),
		.filtered_force   (filtered_force),
		.control_active   (control_active)
	);

endmodule

FILE: dv/filtered_force_pi_regulator_test.sv
// Self-checking testbench for filtered_force_pi_regulator: drives sample words and
// register writes, predicts every result word and compares it field by field.
// Depends on ffpr_pkg and the regulator RTL only.
`timescale 1ns / 1ps

module filtered_force_pi_regulator_test;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int LONG_HOLD       = 300;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int RANDOM_PHASES   = 12;
	localparam int DRAIN_CYCLES    = 40;
	localparam int MAX_REPORTS     = 100;

	// Phase codes that the package leaves unnamed.
	localparam logic [1:0] PH_RETURN = 2'd2;
	localparam logic [1:0] PH_UNUSED = 2'd3;

	typedef struct packed {
		logic [15:0] raw_force;
		logic [1:0]  phase;
		logic        ramp;
	} force_sample_t;

	typedef struct packed {
		logic [23:0] correction;
		logic [15:0] filtered_force;
		logic        control_active;
	} regulation_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b0;
	logic [ffpr_pkg::CFG_AW-1:0]        paddr = '0;
	logic [ffpr_pkg::CFG_DW-1:0]        pwdata = '0;
	logic [ffpr_pkg::CFG_DW-1:0]        prdata;
	logic                               pready;

	logic               sample_valid = 1'b0;
	logic               sample_stall;
	logic signed [15:0] raw_force = '0;
	logic [1:0]         phase = '0;
	logic               ramp_past_enable = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [23:0] correction;
	logic signed [15:0] filtered_force;
	logic               control_active;

	// Predictor state and its copy of the registers.
	ffpr_pkg::cfg_t cfg;
	longint         filt_acc;
	longint         integ_state;

	force_sample_t pending_samples[$];
	regulation_t   expected_regulation[$];
	force_sample_t cur_sample;

	int  error_count = 0;
	int  cycle_count = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  hold_serial = 0;
	int  hold_seen = 0;
	logic idle_on = 1'b1;

	filtered_force_pi_regulator u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.raw_force        (raw_force),
		.phase            (phase),
		.ramp_past_enable (ramp_past_enable),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.correction       (correction),
		.filtered_force   (filtered_force),
		.control_active   (control_active)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_regulation.size());
			$display("filtered_force_pi_regulator_test NOT OK");
			$finish;
		end
	end

	task automatic report_failure(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_span(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// One control tick: filter update, activity decision and the PI law.
	function automatic regulation_t regulate_tick(input force_sample_t s);
		regulation_t r;
		longint raw, x, filt, err, dt, u, corr;
		longint alpha_w, sp, pg, ig, mc, trig;
		logic enabled, active;
		raw     = $signed(s.raw_force);
		alpha_w = cfg.alpha;
		sp      = cfg.setpoint;
		pg      = cfg.pgain;
		ig      = cfg.igain;
		mc      = cfg.maxcorr;
		trig    = $signed(cfg.trigger);
		corr    = 0;
		x = cfg.dir_neg ? raw : -raw;
		if (x > 32767)
			x = 32767;
		filt_acc = round_shift(alpha_w * filt_acc + (65536 - alpha_w) * x * 65536, 16);
		filt = filt_acc >>> 16;
		enabled = (sp != 0) && (mc != 0);
		case (s.phase)
			ffpr_pkg::PH_CONTACT: active = enabled && (s.ramp || filt >= trig);
			ffpr_pkg::PH_SCAN:    active = enabled;
			default:              active = 1'b0;
		endcase
		if (active) begin
			err = sp * 65536 - filt_acc;
			dt = (cfg.period < ffpr_pkg::DT_FLOOR) ? longint'(ffpr_pkg::DT_FLOOR)
				: longint'(cfg.period);
			integ_state = clamp_span(integ_state + round_shift(err * dt, 31),
				longint'(ffpr_pkg::INTEG_LIMIT));
			u = round_shift(pg * err + ig * integ_state * 128, 24);
			u = clamp_span(u, mc);
			corr = cfg.dir_neg ? -u : u;
		end else begin
			integ_state = 0;
		end
		r.correction     = corr[23:0];
		r.filtered_force = filt[15:0];
		r.control_active = active;
		return r;
	endfunction

	function automatic force_sample_t make_sample(input int f, input logic [1:0] ph,
			input logic rmp);
		force_sample_t s;
		if (f > 32767)
			f = 32767;
		if (f < -32768)
			f = -32768;
		s.raw_force = f[15:0];
		s.phase     = ph;
		s.ramp      = rmp;
		return s;
	endfunction

	// Appends one sample word to the end of the pending list.
	function automatic void add_sample(input force_sample_t s);
		pending_samples.insert(pending_samples.size(), s);
	endfunction

	function automatic int pick_value(input int lo, input int hi, input int typical);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return lo;
		if (r < 20)
			return hi;
		if (r < 60)
			return typical;
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic ffpr_pkg::cfg_t random_config();
		ffpr_pkg::cfg_t c;
		c.alpha    = 16'(pick_value(0, 65535, 58982));
		c.setpoint = 15'(pick_value(0, 32767, 512 + int'($urandom_range(0, 2048))));
		c.pgain    = 24'(pick_value(0, 16777215, 400000));
		c.igain    = 24'(pick_value(0, 16777215, 80000));
		c.maxcorr  = 23'(pick_value(0, 8388607, 2500000));
		c.trigger  = 16'(pick_value(-32768, 32767, 128));
		c.period   = 24'(pick_value(0, 16777215, 16777));
		c.dir_neg  = 1'($urandom_range(0, 1));
		return c;
	endfunction

	task automatic apb_write(input logic [ffpr_pkg::REG_IW-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_config(input ffpr_pkg::cfg_t c);
		apb_write(ffpr_pkg::REG_ALPHA, 32'(c.alpha));
		apb_write(ffpr_pkg::REG_SETPOINT, 32'(c.setpoint));
		apb_write(ffpr_pkg::REG_PGAIN, 32'(c.pgain));
		apb_write(ffpr_pkg::REG_IGAIN, 32'(c.igain));
		apb_write(ffpr_pkg::REG_MAXCORR, 32'(c.maxcorr));
		apb_write(ffpr_pkg::REG_TRIGGER, {16'b0, c.trigger});
		apb_write(ffpr_pkg::REG_PERIOD, 32'(c.period));
		apb_write(ffpr_pkg::REG_DIR, 32'(c.dir_neg));
		cfg = c;
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || sample_valid || expected_regulation.size() != 0)
			@(negedge clk);
	endtask

	// Extremes of force, every phase code, and contact with the ramp flag both ways.
	task automatic queue_directed();
		add_sample(make_sample(0, PH_RETURN, 1'b0));
		add_sample(make_sample(32767, PH_UNUSED, 1'b1));
		add_sample(make_sample(0, ffpr_pkg::PH_CONTACT, 1'b0));
		add_sample(make_sample(0, ffpr_pkg::PH_CONTACT, 1'b1));
		add_sample(make_sample(-32768, ffpr_pkg::PH_SCAN, 1'b0));
		repeat (3)
			add_sample(make_sample(32767, ffpr_pkg::PH_SCAN, 1'b0));
		repeat (2)
			add_sample(make_sample(32767, ffpr_pkg::PH_CONTACT, 1'b0));
		add_sample(make_sample(-1, ffpr_pkg::PH_SCAN, 1'b1));
		add_sample(make_sample(-32768, PH_RETURN, 1'b1));
	endtask

	// A plausible contact cycle: ramp into contact, scan around the setpoint, retract.
	task automatic queue_episode(inout int added);
		int level, spread, n_contact, n_scan, n_back, f, sgn;
		sgn = cfg.dir_neg ? 1 : -1;
		level = int'(cfg.setpoint) + int'($urandom_range(0, 1024)) - 512;
		case ($urandom_range(0, 2))
			0: spread = 16;
			1: spread = 256;
			default: spread = 4096;
		endcase
		n_contact = $urandom_range(2, 12);
		n_scan    = $urandom_range(5, 30);
		n_back    = $urandom_range(1, 4);
		for (int i = 0; i < n_contact; i++) begin
			f = level * (i + 1) / n_contact + int'($urandom_range(0, 32)) - 16;
			add_sample(make_sample(sgn * f, ffpr_pkg::PH_CONTACT,
				i >= n_contact / 2));
		end
		for (int i = 0; i < n_scan; i++) begin
			f = level + int'($urandom_range(0, 2 * spread)) - spread;
			add_sample(make_sample(sgn * f, ffpr_pkg::PH_SCAN,
				1'($urandom_range(0, 1))));
		end
		for (int i = 0; i < n_back; i++) begin
			f = level / (i + 2);
			add_sample(make_sample(sgn * f,
				($urandom_range(0, 3) == 0) ? PH_UNUSED : PH_RETURN,
				1'($urandom_range(0, 1))));
		end
		added += n_contact + n_scan + n_back;
	endtask

	task automatic queue_random_phase();
		int added;
		added = 0;
		while (added < ITEMS_PER_PHASE) begin
			if ($urandom_range(0, 99) < 80) begin
				queue_episode(added);
			end else begin
				repeat ($urandom_range(1, 5)) begin
					add_sample(make_sample(int'($urandom_range(0, 65535)) - 32768,
						2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
					added++;
				end
			end
		end
	endtask

	always @(posedge clk) begin : sample_driver
		logic offer;
		if (arst_n) begin
			offer = sample_valid;
			if (sample_valid && !sample_stall) begin
				expected_regulation.insert(expected_regulation.size(),
					regulate_tick(cur_sample));
				offer = 1'b0;
				send_gap = idle_on ? pick_gap() : 0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_samples.size() > 0) begin
					cur_sample = pending_samples.pop_front();
					offer = 1'b1;
					raw_force        <= cur_sample.raw_force;
					phase            <= cur_sample.phase;
					ramp_past_enable <= cur_sample.ramp;
				end
			end
			sample_valid <= offer;
		end
	end

	always @(posedge clk) begin : result_monitor
		regulation_t want;
		logic stall_next;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_regulation.size() == 0) begin
					report_failure($sformatf("result word with nothing expected: %0d %0d %0b",
						correction, filtered_force, control_active));
				end else begin
					want = expected_regulation.pop_front();
					if (correction !== want.correction)
						report_failure($sformatf("correction %0d, expected %0d", correction,
							$signed(want.correction)));
					if (filtered_force !== want.filtered_force)
						report_failure($sformatf("filtered_force %0d, expected %0d",
							filtered_force, $signed(want.filtered_force)));
					if (control_active !== want.control_active)
						report_failure($sformatf("control_active %0b, expected %0b",
							control_active, want.control_active));
				end
			end
			// A new hold request from the stimulus starts a long back-pressure stretch.
			if (hold_seen != hold_serial) begin
				hold_seen = hold_serial;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else begin
				stall_left = idle_on ? pick_gap() : 0;
				stall_next = stall_left > 0;
				if (stall_next)
					stall_left--;
			end
			result_stall <= stall_next;
		end
	end

	initial begin
		ffpr_pkg::cfg_t c;
		cfg.alpha    = ffpr_pkg::RST_ALPHA;
		cfg.setpoint = ffpr_pkg::RST_SETPOINT;
		cfg.pgain    = ffpr_pkg::RST_PGAIN;
		cfg.igain    = ffpr_pkg::RST_IGAIN;
		cfg.maxcorr  = ffpr_pkg::RST_MAXCORR;
		cfg.trigger  = ffpr_pkg::RST_TRIGGER;
		cfg.period   = ffpr_pkg::RST_PERIOD;
		cfg.dir_neg  = ffpr_pkg::RST_DIR;
		filt_acc    = 0;
		integ_state = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		queue_directed();
		wait_drained();

		// Positive direction, instant filter, lowest trigger and a zero period.
		c = cfg;
		c.alpha   = 16'd0;
		c.trigger = 16'sh8000;
		c.period  = 24'd0;
		c.dir_neg = 1'b0;
		apply_config(c);
		queue_directed();
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					c.alpha    = 16'hFFFF;
					c.setpoint = 15'h7FFF;
					c.pgain    = 24'hFFFFFF;
					c.igain    = 24'hFFFFFF;
					c.maxcorr  = 23'h7FFFFF;
					c.trigger  = 16'sh7FFF;
					c.period   = 24'hFFFFFF;
					c.dir_neg  = 1'b1;
				end
				1: begin
					c = random_config();
					c.setpoint = 15'd0;
				end
				2: begin
					c = random_config();
					c.maxcorr = 23'd0;
				end
				default: c = random_config();
			endcase
			apply_config(c);
			idle_on = (ph % 3) != 2;
			queue_random_phase();
			if (ph == 4)
				hold_serial++;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("filtered_force_pi_regulator_test OK");
		else
			$display("filtered_force_pi_regulator_test NOT OK");
		$finish;
	end

endmodule
